>>> rtl/core/phase_guided_counter_multiplexer_top_assert.svh
// Assertion macros for the phase guided counter multiplexer checker.
// Pulled in by pgcm_checker only; needs nothing else.
`ifndef PHASE_GUIDED_COUNTER_MULTIPLEXER_TOP_ASSERT_SVH
`define PHASE_GUIDED_COUNTER_MULTIPLEXER_TOP_ASSERT_SVH

// same-cycle implication
`define PGCM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PGCM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pgcm_pkg.sv
// Shared types and constants of the phase guided counter multiplexer.
// No dependencies; imported by the controller, datapath and top level.
package pgcm_pkg;

   localparam int FIELD_W      = 4;   // phase, prediction, event_index
   localparam int MAX_ACTIVE_W = 3;
   localparam int NUM_EVENTS_W = 5;
   localparam int CSR_DATA_W   = 5;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ACTIVE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_EVENTS = 1'b1;

   localparam logic [MAX_ACTIVE_W-1:0] MAX_ACTIVE_RST = 3'd4;
   localparam logic [NUM_EVENTS_W-1:0] NUM_EVENTS_RST = 5'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PART,
      ST_MOVE,
      ST_SEL,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // latch phases and limits, clear partition counters
      logic part;      // walk ended phase queue
      logic move;      // append previously active events
      logic commit;    // mark ended phase seen, start selection
      logic sel;       // walk predicted phase queue
      logic emit_adv;  // result beat taken
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic part_done;
      logic move_done;
      logic sel_done;
      logic regs_zero;
      logic emit_last;
   } sts_type;

endpackage

>>> rtl/core/pgcm_ram.sv
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
module pgcm_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/pgcm_ctrl.sv
// Sequencer of the phase guided counter multiplexer.
// Uses pgcm_pkg; drives cmd_type to pgcm_dp and reads sts_type back.
module pgcm_ctrl
   import pgcm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PART;
            end
         end
         ST_PART: begin
            cmd.part = 1'b1;
            if (sts.part_done) begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            if (sts.move_done) begin
               cmd.commit = 1'b1;
               state_in   = ST_SEL;
            end
         end
         ST_SEL: begin
            if (sts.regs_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.sel = 1'b1;
               if (sts.sel_done) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.emit_adv = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/pgcm_dp.sv
// Datapath: config registers, seen flags, active list, queue walk counters.
// Uses pgcm_pkg; drives the queue RAM ports, takes commands from pgcm_ctrl.
module pgcm_dp
   import pgcm_pkg::*;
#(
   parameter int NUM_PHASES   = 16,
   parameter int NUM_EVENTS   = 16,
   parameter int MAX_COUNTERS = 4,
   localparam int PW   = (NUM_PHASES > 2) ? $clog2(NUM_PHASES) : 1,
   localparam int IW   = (NUM_EVENTS > 2) ? $clog2(NUM_EVENTS) : 1,
   localparam int AW   = PW + IW
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic [FIELD_W-1:0]      phase,
   input  logic [FIELD_W-1:0]      prediction,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output logic [FIELD_W-1:0]      event_index,
   output logic                    is_last,
   output logic                    none_active,
   output logic                    ram_we,
   output logic [AW-1:0]           ram_waddr,
   output logic [IW-1:0]           ram_wdata,
   output logic                    ram_re,
   output logic [AW-1:0]           ram_raddr,
   input  logic [IW-1:0]           ram_rdata
);

   localparam int CNTW    = $clog2(NUM_EVENTS + 1);   // queue position counters
   localparam int CW      = $clog2(MAX_COUNTERS + 1); // active counts
   localparam int MW      = (MAX_COUNTERS > 2) ? $clog2(MAX_COUNTERS) : 1;
   localparam int SUMW    = (CNTW > CW) ? CNTW : CW;
   localparam int REG_CAP = (NUM_EVENTS < 31) ? NUM_EVENTS : 31;

   // phase id modulo NUM_PHASES, a 16 entry table folded at elaboration
   function automatic logic [PW-1:0] phase_mod(input logic [FIELD_W-1:0] v);
      logic [PW-1:0] r;
      r = '0;
      for (int k = 0; k < 16; k++) begin
         if (v == FIELD_W'(k)) begin
            r = PW'(k % NUM_PHASES);
         end
      end
      return r;
   endfunction

   logic [MAX_ACTIVE_W-1:0] max_active_ff, max_active_in;
   logic [NUM_EVENTS_W-1:0] num_events_ff, num_events_in;
   logic [NUM_PHASES-1:0]   seen_ff, seen_in;
   logic [PW-1:0]           ended_ff, ended_in;
   logic [PW-1:0]           pred_ff, pred_in;
   logic [CW-1:0]           lim_ff, lim_in;
   logic [NUM_EVENTS_W-1:0] regs_ff, regs_in;
   logic [CNTW-1:0]         rd_idx_ff, rd_idx_in;
   logic                    pend_ff, pend_in;
   logic [IW-1:0]           pidx_ff, pidx_in;
   logic [CNTW-1:0]         nk_ff, nk_in;
   logic [CW-1:0]           nm_ff, nm_in;
   logic [CW-1:0]           mv_ff, mv_in;
   logic [CW-1:0]           n_ff, n_in;      // doubles as active_total
   logic [CW-1:0]           e_ff, e_in;
   logic [IW-1:0]           act_ff [MAX_COUNTERS];
   logic [IW-1:0]           act_in [MAX_COUNTERS];
   logic [IW-1:0]           moved_ff [MAX_COUNTERS];
   logic [IW-1:0]           moved_in [MAX_COUNTERS];

   logic          walk_seen;
   logic [IW-1:0] ev_rd;
   logic          ev_active;
   logic          issue;
   logic          at_end;
   logic [SUMW-1:0] tail_pos;

   assign walk_seen = cmd.sel ? seen_ff[pred_ff] : seen_ff[ended_ff];
   // a never-written queue reads as 0, 1, 2, ...
   assign ev_rd     = walk_seen ? ram_rdata : pidx_ff;
   assign at_end    = (rd_idx_ff == CNTW'(NUM_EVENTS));
   assign issue     = !at_end && (cmd.part || (cmd.sel && (n_ff != lim_ff)));
   assign tail_pos  = SUMW'(nk_ff) + SUMW'(mv_ff);

   always_comb begin
      ev_active = 1'b0;
      for (int j = 0; j < MAX_COUNTERS; j++) begin
         if ((CW'(j) < n_ff) && (act_ff[j] == ev_rd)) begin
            ev_active = 1'b1;
         end
      end
   end

   // queue RAM
   assign ram_re    = issue;
   assign ram_raddr = {cmd.sel ? pred_ff : ended_ff, rd_idx_ff[IW-1:0]};

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {ended_ff, nk_ff[IW-1:0]};
      ram_wdata = ev_rd;
      if (cmd.part && pend_ff && !ev_active) begin
         ram_we = 1'b1;
      end else if (cmd.move && (mv_ff != nm_ff)) begin
         ram_we    = 1'b1;
         ram_waddr = {ended_ff, tail_pos[IW-1:0]};
         ram_wdata = moved_ff[mv_ff[MW-1:0]];
      end
   end

   // next state
   always_comb begin
      max_active_in = max_active_ff;
      num_events_in = num_events_ff;
      seen_in       = seen_ff;
      ended_in      = ended_ff;
      pred_in       = pred_ff;
      lim_in        = lim_ff;
      regs_in       = regs_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = issue;
      pidx_in       = rd_idx_ff[IW-1:0];
      nk_in         = nk_ff;
      nm_in         = nm_ff;
      mv_in         = mv_ff;
      n_in          = n_ff;
      e_in          = e_ff;
      act_in        = act_ff;
      moved_in      = moved_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_MAX_ACTIVE: max_active_in = csr_wdata[MAX_ACTIVE_W-1:0];
            CSR_NUM_EVENTS: num_events_in = csr_wdata[NUM_EVENTS_W-1:0];
            default: ;
         endcase
      end

      if (issue) begin
         rd_idx_in = rd_idx_ff + CNTW'(1);
      end

      if (cmd.part && pend_ff) begin
         if (ev_active) begin
            moved_in[nm_ff[MW-1:0]] = ev_rd;
            nm_in = nm_ff + CW'(1);
         end else begin
            nk_in = nk_ff + CNTW'(1);
         end
      end

      if (cmd.move && (mv_ff != nm_ff)) begin
         mv_in = mv_ff + CW'(1);
      end

      if (cmd.sel && pend_ff && (n_ff != lim_ff) &&
          ({{(32-IW){1'b0}}, ev_rd} < {{(32-NUM_EVENTS_W){1'b0}}, regs_ff})) begin
         act_in[n_ff[MW-1:0]] = ev_rd;
         n_in = n_ff + CW'(1);
      end

      if (cmd.emit_adv) begin
         e_in = e_ff + CW'(1);
      end

      if (cmd.load) begin
         ended_in  = phase_mod(phase);
         pred_in   = phase_mod(prediction);
         if (max_active_ff == '0) begin
            lim_in = CW'(1);
         end else if (32'(max_active_ff) > MAX_COUNTERS) begin
            lim_in = CW'(MAX_COUNTERS);
         end else begin
            lim_in = CW'(max_active_ff);
         end
         if (32'(num_events_ff) > REG_CAP) begin
            regs_in = NUM_EVENTS_W'(REG_CAP);
         end else begin
            regs_in = num_events_ff;
         end
         rd_idx_in = '0;
         pend_in   = 1'b0;
         nk_in     = '0;
         nm_in     = '0;
         mv_in     = '0;
      end

      if (cmd.commit) begin
         seen_in[ended_ff] = 1'b1;
         rd_idx_in = '0;
         pend_in   = 1'b0;
         n_in      = '0;
         e_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_active_ff <= MAX_ACTIVE_RST;
         num_events_ff <= NUM_EVENTS_RST;
         seen_ff       <= '0;
         rd_idx_ff     <= '0;
         pend_ff       <= 1'b0;
         nk_ff         <= '0;
         nm_ff         <= '0;
         mv_ff         <= '0;
         n_ff          <= '0;
         e_ff          <= '0;
      end else begin
         max_active_ff <= max_active_in;
         num_events_ff <= num_events_in;
         seen_ff       <= seen_in;
         rd_idx_ff     <= rd_idx_in;
         pend_ff       <= pend_in;
         nk_ff         <= nk_in;
         nm_ff         <= nm_in;
         mv_ff         <= mv_in;
         n_ff          <= n_in;
         e_ff          <= e_in;
      end
      ended_ff <= ended_in;
      pred_ff  <= pred_in;
      lim_ff   <= lim_in;
      regs_ff  <= regs_in;
      pidx_ff  <= pidx_in;
      act_ff   <= act_in;
      moved_ff <= moved_in;
   end

   // status
   assign sts.part_done = at_end && !pend_ff;
   assign sts.move_done = (mv_ff == nm_ff);
   assign sts.sel_done  = ((n_ff == lim_ff) || at_end) && !pend_ff;
   assign sts.regs_zero = (regs_ff == '0);
   assign sts.emit_last = sts.regs_zero || ((e_ff + CW'(1)) == n_ff);

   // result beat
   assign none_active = sts.regs_zero;
   assign is_last     = sts.emit_last;
   assign event_index = sts.regs_zero ? '0 : FIELD_W'(act_ff[e_ff[MW-1:0]]);

endmodule

>>> rtl/core/phase_guided_counter_multiplexer_top.sv
// Top level of the phase guided counter multiplexer.
// Uses pgcm_pkg, pgcm_ctrl, pgcm_dp and pgcm_ram.
//
//   channel | dir | beat contents
//   req     | in  | tdata[3:0] phase, tdata[7:4] prediction
//   rsp     | out | tdata[3:0] event_index, tlast is_last, tuser none_active
//   csr     | in  | csr_index 0 max_active, 1 num_events; csr_wdata value
//
// One request at a time: the ended phase queue is walked through the RAM read
// port, the events that were active are appended, the predicted queue is picked
// from, then the result beats go out as they are taken.
// Both walks share the single RAM port pair.
// Reset (synchronous) clears the seen flags and all counters; no RAM sweep.
// A stalled rsp beat holds; req_tready stays low until the last beat goes.
module phase_guided_counter_multiplexer_top
   import pgcm_pkg::*;
#(
   parameter int NUM_PHASES   = 16,
   parameter int NUM_EVENTS   = 16,
   parameter int MAX_COUNTERS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: [3:0] phase, [7:4] prediction
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   // result: [3:0] event_index, [7:4] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   // result tuser: [0] none_active
   output logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PW    = (NUM_PHASES > 2) ? $clog2(NUM_PHASES) : 1;
   localparam int IW    = (NUM_EVENTS > 2) ? $clog2(NUM_EVENTS) : 1;
   localparam int AW    = PW + IW;
   // queue store addressed {phase, position}
   localparam int DEPTH = 2 ** AW;

   cmd_type cmd;
   sts_type sts;

   logic [FIELD_W-1:0] event_index;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [IW-1:0]      ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [IW-1:0]      ram_rdata;

   pgcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pgcm_dp #(
      .NUM_PHASES   (NUM_PHASES),
      .NUM_EVENTS   (NUM_EVENTS),
      .MAX_COUNTERS (MAX_COUNTERS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .phase       (req_tdata[3:0]),
      .prediction  (req_tdata[7:4]),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .event_index (event_index),
      .is_last     (rsp_tlast),
      .none_active (rsp_tuser),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata)
   );

   // per-phase event queues
   pgcm_ram #(
      .WIDTH (IW),
      .DEPTH (DEPTH)
   ) u_queue_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_tdata = {4'b0000, event_index};

endmodule

>>> rtl/core/pgcm_checker.sv
// Port-level checker for the phase guided counter multiplexer, bound to the top.
// Uses the macros of phase_guided_counter_multiplexer_top_assert.svh.
`include "phase_guided_counter_multiplexer_top_assert.svh"

module pgcm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // stalled result beat stays up
   `PGCM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp beat dropped")

   // empty event set gives a single zero beat
   `PGCM_ASSERT_NOW(a_none_beat, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata == 8'h00), "bad none_active beat")

   // one request at a time: no intake while results are pending
   `PGCM_ASSERT_NOW(a_no_overlap, rsp_tvalid, !req_tready, "request taken during results")

   // after the last beat the block is ready again
   `PGCM_ASSERT_NEXT(a_ready_after, rsp_tvalid && rsp_tready && rsp_tlast, req_tready && !rsp_tvalid, "not idle after last beat")

endmodule

bind phase_guided_counter_multiplexer_top pgcm_checker u_pgcm_checker (.*);

>>> verif/phase_guided_counter_multiplexer_top_tb.sv
// Self-checking bench for phase_guided_counter_multiplexer_top: directed table, then random
// phase sequences under four idle mixes. Needs pgcm_pkg and the RTL, nothing else.
module phase_guided_counter_multiplexer_top_tb
   import pgcm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPH  = 16;
   localparam int NEV  = 16;
   localparam int NCNT = 4;

   typedef struct packed {
      logic [3:0] event_index;
      logic       is_last;
      logic       none_active;
   } beat_type;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type                kind;
      logic [CSR_INDEX_W-1:0]      sel;
      logic [CSR_DATA_W-1:0]       val;
      logic [3:0]                  ph;
      logic [3:0]                  pr;
      bit                          known;   // expected beats typed in the row
      logic [2:0]                  n;
      logic [NCNT-1:0][3:0]        ev;      // ev[0] first beat
      bit                          none;
   } row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;     // [3:0] phase, [7:4] prediction
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;          // [3:0] event_index, [7:4] zero
   logic                   rsp_tlast;
   logic                   rsp_tuser;          // [0] none_active
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   phase_guided_counter_multiplexer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // scheduler mirror
   logic [MAX_ACTIVE_W-1:0] cfg_max_active = MAX_ACTIVE_RST;
   logic [NUM_EVENTS_W-1:0] cfg_num_events = NUM_EVENTS_RST;
   bit                      phase_known [NPH];
   logic [3:0]              event_order [NPH][NEV];
   logic [3:0]              live_events [NCNT];
   int                      live_total = 0;
   beat_type                step_beats [NCNT];

   beat_type expected_beats [$];
   row_type  directed [$];
   int       error_count    = 0;
   int       send_idle_pct  = 0;
   int       recv_stall_pct = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic void queue_beat(input beat_type b);
      expected_beats.insert(expected_beats.size(), b);
   endfunction

   function automatic void prime_order(input int p);
      if (!phase_known[p]) begin
         phase_known[p] = 1'b1;
         for (int i = 0; i < NEV; i++) event_order[p][i] = 4'(i);
      end
   endfunction

   // Rotate the ended phase's order, then pick from the predicted one.
   // Fills step_beats and returns the number of beats.
   function automatic int choose_counters(input logic [3:0] ended, input logic [3:0] pred);
      int         lim;
      int         regs;
      int         nk;
      int         nm;
      int         n;
      bit         hit;
      logic [3:0] keep [NEV];
      logic [3:0] moved [NEV];
      lim  = (cfg_max_active == 0) ? 1 : (cfg_max_active > NCNT ? NCNT : int'(cfg_max_active));
      regs = (cfg_num_events > NEV) ? NEV : int'(cfg_num_events);
      nk   = 0;
      nm   = 0;
      n    = 0;
      prime_order(ended);
      for (int i = 0; i < NEV; i++) begin
         hit = 1'b0;
         for (int j = 0; j < live_total; j++)
            if (live_events[j] == event_order[ended][i]) hit = 1'b1;
         if (hit) begin
            moved[nm] = event_order[ended][i];
            nm++;
         end else begin
            keep[nk] = event_order[ended][i];
            nk++;
         end
      end
      for (int i = 0; i < nk; i++) event_order[ended][i] = keep[i];
      for (int i = 0; i < nm; i++) event_order[ended][nk + i] = moved[i];
      live_total = 0;
      prime_order(pred);
      if (regs == 0) begin
         step_beats[0] = '{event_index: 4'd0, is_last: 1'b1, none_active: 1'b1};
         return 1;
      end
      for (int i = 0; i < NEV && n < lim; i++)
         if (event_order[pred][i] < regs) begin
            live_events[n] = event_order[pred][i];
            n++;
         end
      live_total = n;
      for (int i = 0; i < n; i++)
         step_beats[i] = '{event_index: live_events[i], is_last: (i == n - 1), none_active: 1'b0};
      return n;
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] sel,
                                   input logic [CSR_DATA_W-1:0] val);
      row_type r;
      r      = '0;
      r.kind = ROW_CSR;
      r.sel  = sel;
      r.val  = val;
      directed.insert(directed.size(), r);
   endfunction

   function automatic void add_item(input logic [3:0] ph, input logic [3:0] pr, input bit known,
                                    input logic [2:0] n, input logic [NCNT-1:0][3:0] ev,
                                    input bit none);
      row_type r;
      r       = '0;
      r.kind  = ROW_ITEM;
      r.ph    = ph;
      r.pr    = pr;
      r.known = known;
      r.n     = n;
      r.ev    = ev;
      r.none  = none;
      directed.insert(directed.size(), r);
   endfunction

   // Waits for the block to go idle with nothing outstanding.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] sel, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (sel == CSR_MAX_ACTIVE) cfg_max_active = val[MAX_ACTIVE_W-1:0];
      else cfg_num_events = val[NUM_EVENTS_W-1:0];
   endtask

   // One request beat; returns at the edge that took it.
   task automatic send_phase(input logic [3:0] ph, input logic [3:0] pr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pr, ph};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_and_predict(input logic [3:0] ph, input logic [3:0] pr);
      int n;
      send_phase(ph, pr);
      n = choose_counters(ph, pr);
      for (int i = 0; i < n; i++) queue_beat(step_beats[i]);
   endtask

   // Result side: random stall and beat check.
   always @(posedge clock) begin
      beat_type want;
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat, event_index", rsp_tdata, -1);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tdata !== {4'd0, want.event_index})
               report_mismatch("event_index", rsp_tdata, want.event_index);
            if (rsp_tlast !== want.is_last)
               report_mismatch("is_last", rsp_tlast, want.is_last);
            if (rsp_tuser !== want.none_active)
               report_mismatch("none_active", rsp_tuser, want.none_active);
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("phase_guided_counter_multiplexer_top test failed");
      $finish;
   end

   initial begin
      int         waited;
      logic [3:0] ph;
      logic [3:0] pr;
      logic [3:0] last_pred;
      logic [2:0] max_pick;
      logic [4:0] num_pick;

      // nothing registered after reset: a single none beat each
      add_item(4'd0,  4'd0,  1, 3'd1, '0, 1);
      add_item(4'd15, 4'd15, 1, 3'd1, '0, 1);
      add_csr(CSR_NUM_EVENTS, 5'd16);
      // fresh predicted phase starts 0..15
      add_item(4'd0, 4'd1, 1, 3'd4, {4'd3, 4'd2, 4'd1, 4'd0}, 0);
      // ended == predicted: the reordered queue is read
      add_item(4'd1, 4'd1, 1, 3'd4, {4'd7, 4'd6, 4'd5, 4'd4}, 0);
      add_csr(CSR_MAX_ACTIVE, 3'd0);           // zero counts as one
      add_item(4'd1, 4'd2, 1, 3'd1, '0, 0);
      add_csr(CSR_MAX_ACTIVE, 3'd7);           // saturates to four
      add_item(4'd2, 4'd1, 1, 3'd4, {4'd11, 4'd10, 4'd9, 4'd8}, 0);
      add_csr(CSR_NUM_EVENTS, 5'd31);          // saturates to sixteen
      add_item(4'd15, 4'd14, 0, '0, '0, 0);
      add_item(4'd14, 4'd14, 0, '0, '0, 0);
      add_csr(CSR_MAX_ACTIVE, 3'd4);
      add_csr(CSR_NUM_EVENTS, 5'd1);           // shrink after scheduling began
      add_item(4'd14, 4'd3, 0, '0, '0, 0);
      add_item(4'd3,  4'd3, 0, '0, '0, 0);
      add_csr(CSR_NUM_EVENTS, 5'd0);
      add_item(4'd3, 4'd8, 1, 3'd1, '0, 1);
      add_item(4'd8, 4'd9, 1, 3'd1, '0, 1);
      add_csr(CSR_NUM_EVENTS, 5'd6);
      add_csr(CSR_MAX_ACTIVE, 3'd2);
      add_item(4'd9,  4'd9,  0, '0, '0, 0);
      add_item(4'd9,  4'd9,  0, '0, '0, 0);
      add_item(4'd9,  4'd10, 0, '0, '0, 0);
      add_item(4'd10, 4'd9,  0, '0, '0, 0);
      add_csr(CSR_MAX_ACTIVE, 3'd3);
      add_csr(CSR_NUM_EVENTS, 5'd16);          // grow back
      add_item(4'd7,  4'd11, 0, '0, '0, 0);
      add_item(4'd11, 4'd15, 0, '0, '0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k]) begin
         if (directed[k].kind == ROW_CSR) begin
            drain();
            write_csr(directed[k].sel, directed[k].val);
         end else if (directed[k].known) begin
            send_phase(directed[k].ph, directed[k].pr);
            void'(choose_counters(directed[k].ph, directed[k].pr));   // keep the mirror in step
            if (directed[k].none)
               queue_beat('{event_index: 4'd0, is_last: 1'b1, none_active: 1'b1});
            else
               for (int i = 0; i < directed[k].n; i++)
                  queue_beat('{event_index: directed[k].ev[i],
                               is_last: (i == directed[k].n - 1),
                               none_active: 1'b0});
         end else begin
            send_and_predict(directed[k].ph, directed[k].pr);
         end
      end

      // random part: mostly chained phases (ended = last prediction)
      last_pred = 4'd11;
      for (int mode = 0; mode < 4; mode++) begin
         drain();
         case (mode)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
               max_pick = 3'd4;    num_pick = 5'd16;
            end
            1: begin
               send_idle_pct = 54; recv_stall_pct = 0;
               max_pick = 3'd1;    num_pick = 5'($urandom_range(17, 31));
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 54;
               max_pick = 3'($urandom_range(0, 7));
               num_pick = 5'($urandom_range(1, 15));
            end
            default: begin
               send_idle_pct = 16; recv_stall_pct = 16;
               max_pick = 3'($urandom_range(5, 7));
               num_pick = 5'($urandom_range(0, 16));
            end
         endcase
         write_csr(CSR_MAX_ACTIVE, CSR_DATA_W'(max_pick));
         write_csr(CSR_NUM_EVENTS, num_pick);
         for (int k = 0; k < 20; k++) begin
            if ($urandom_range(0, 9) < 7) ph = last_pred;
            else ph = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 4) == 0) pr = ph;
            else pr = 4'($urandom_range(0, 15));
            send_and_predict(ph, pr);
            last_pred = pr;
            // sender holds off until the result side has caught up
            if (k == 12 || $urandom_range(0, 24) == 0) drain();
         end
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_beats.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (expected_beats.size() != 0)
         report_mismatch("beats never delivered", 0, expected_beats.size());

      if (error_count == 0) begin
         $display("phase_guided_counter_multiplexer_top test passed");
      end else begin
         $display("phase_guided_counter_multiplexer_top test failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pgcm_pkg.sv
rtl/core/pgcm_ram.sv
rtl/core/pgcm_ctrl.sv
rtl/core/pgcm_dp.sv
rtl/core/phase_guided_counter_multiplexer_top.sv
rtl/core/pgcm_checker.sv
verif/phase_guided_counter_multiplexer_top_tb.sv
